// ===== design/x86e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86e_pkg
// shared types and constants for the three-address code emitter
// ----------------------------------------------------------------------------
package x86e_pkg;

  localparam int unsigned SlotCount    = 256;
  localparam int unsigned SlotIdxBits  = $clog2(SlotCount);
  localparam int unsigned SlotCntBits  = SlotIdxBits + 1;
  localparam int unsigned TempRegs     = 7;
  localparam int unsigned VarIdBits    = 16;
  localparam int unsigned CodeAddrBits = 16;
  localparam int unsigned FrameMax     = 4095;
  localparam int unsigned BufLen       = 40;
  localparam int unsigned BufIdxBits   = 6;

  localparam logic [2:0] ActBegin = 3'd0;
  localparam logic [2:0] ActEnd   = 3'd1;
  localparam logic [2:0] ActAssign = 3'd2;
  localparam logic [2:0] ActBinop = 3'd3;
  localparam logic [2:0] ActFinal = 3'd4;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpMod = 3'd4;

  localparam logic [1:0] KindConst = 2'd0;
  localparam logic [1:0] KindVar   = 2'd1;
  localparam logic [1:0] KindTemp  = 2'd2;

  localparam logic [1:0] ItemByte  = 2'd0;
  localparam logic [1:0] ItemPatch = 2'd1;
  localparam logic [1:0] ItemSize  = 2'd2;
  localparam logic [1:0] ItemFault = 2'd3;

  localparam logic [2:0] FltNone    = 3'd0;
  localparam logic [2:0] FltUnknown = 3'd1;
  localparam logic [2:0] FltSlots   = 3'd2;
  localparam logic [2:0] FltBuffer  = 3'd3;
  localparam logic [2:0] FltOperand = 3'd4;

  // search request to the slot table
  typedef struct packed {
    logic                 start;
    logic [VarIdBits-1:0] key;
    logic [SlotCntBits-1:0] count;
  } srch_req_t;

  typedef struct packed {
    logic                   done;
    logic                   found;
    logic [SlotIdxBits-1:0] idx;
  } srch_rsp_t;

  typedef struct packed {
    logic                   we;
    logic [SlotIdxBits-1:0] addr;
    logic [VarIdBits-1:0]   key;
  } slot_wr_t;

  function automatic logic [7:0] rexw(input logic [3:0] r, input logic [3:0] rm);
    rexw = 8'h48 | {5'd0, r[3], 2'd0} | {7'd0, rm[3]};
  endfunction

  function automatic logic [31:0] slot_disp(input logic [SlotIdxBits-1:0] i);
    slot_disp = 32'd0 - (32'd16 + {{(29 - SlotIdxBits){1'b0}}, i, 3'd0});
  endfunction

endpackage

// ===== design/x86e_slot_tbl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86e_slot_tbl
// slot key memory with a sequential search, one entry per cycle
// ----------------------------------------------------------------------------
module x86e_slot_tbl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  x86e_pkg::srch_req_t   req_i,
  input  x86e_pkg::slot_wr_t    wr_i,
  output x86e_pkg::srch_rsp_t   rsp_o
);

  typedef enum logic [1:0] {SIdle, SRead, SDone} state_e;

  logic [x86e_pkg::VarIdBits-1:0]   mem_q [x86e_pkg::SlotCount];
  logic [x86e_pkg::VarIdBits-1:0]   rdata_q;
  logic [x86e_pkg::SlotCntBits-1:0] ptr_q, cnt_q;
  logic [x86e_pkg::VarIdBits-1:0]   key_q;
  logic [x86e_pkg::SlotIdxBits-1:0] hit_q;
  logic                             found_q;
  state_e                           state_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.key;
    end
    rdata_q <= mem_q[ptr_q[x86e_pkg::SlotIdxBits-1:0]];
  end

  // ptr_q addresses the read; rdata_q holds entry ptr_q-1 in SRead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ptr_q   <= '0;
      cnt_q   <= '0;
      key_q   <= '0;
      hit_q   <= '0;
      found_q <= 1'b0;
    end else begin
      case (state_q)
        SIdle: begin
          if (req_i.start) begin
            key_q   <= req_i.key;
            cnt_q   <= req_i.count;
            found_q <= 1'b0;
            if (req_i.count == '0) begin
              state_q <= SDone;
            end else begin
              ptr_q   <= {{(x86e_pkg::SlotCntBits-1){1'b0}}, 1'b1};
              state_q <= SRead;
            end
          end else begin
            ptr_q <= '0;
          end
        end
        SRead: begin
          if (rdata_q == key_q) begin
            found_q <= 1'b1;
            hit_q   <= x86e_pkg::SlotIdxBits'(ptr_q - 1'b1);
            state_q <= SDone;
          end else if (ptr_q >= cnt_q) begin
            state_q <= SDone;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        SDone: begin
          ptr_q   <= '0;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign rsp_o.done  = (state_q == SDone);
  assign rsp_o.found = found_q;
  assign rsp_o.idx   = hit_q;

endmodule

// ===== design/x86_64_three_address_code_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_64_three_address_code_emitter
// encodes three-address IR requests into x86-64 bytes, one byte per cycle
// ----------------------------------------------------------------------------
// steps: a check state, up to three slot searches through the one-port slot memory,
//   a build state, then the results, one byte per cycle
// requests: one at a time, each finished before the next is taken
// reset: control state clears, slot memory is not cleared (fill count)
// results cannot be stalled by the receiver
module x86_64_three_address_code_emitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [2:0]  bin_op_i,
  input  logic [1:0]  dest_kind_i,
  input  logic [15:0] dest_ident_i,
  input  logic [1:0]  src_a_kind_i,
  input  logic [15:0] src_a_ident_i,
  input  logic signed [63:0] src_a_value_i,
  input  logic [1:0]  src_b_kind_i,
  input  logic [15:0] src_b_ident_i,
  input  logic signed [63:0] src_b_value_i,
  output logic        strobe_o,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  code_byte_o,
  output logic [15:0] position_o,
  output logic [11:0] patch_value_o,
  output logic [2:0]  fault_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    SIdle, SCheck, SSrchD, SSrchA, SSrchB, SBuild, SEmit, SFinal
  } state_e;

  localparam int unsigned SIB = x86e_pkg::SlotIdxBits;
  localparam int unsigned SCB = x86e_pkg::SlotCntBits;
  localparam int unsigned BIB = x86e_pkg::BufIdxBits;

  state_e state_q;
  logic [15:0] cap_q;
  logic [SCB-1:0] scnt_q;
  logic [11:0] frame_q;
  logic [15:0] cur_q;
  logic [15:0] ppos_q [2];
  logic [1:0]  pval_q;

  logic [2:0]  act_q, op_q;
  logic [1:0]  dk_q, ak_q, bk_q;
  logic [15:0] di_q, ai_q, bi_q;
  logic [63:0] av_q, bv_q;
  logic        dfound_q, afound_q, bfound_q;
  logic [SIB-1:0] dslot_q, aslot_q, bslot_q;

  logic [BIB-1:0] bidx_q;
  logic [1:0]  fcnt_q;

  logic        strobe_q, last_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [15:0] pos_q;
  logic [11:0] pv_q;
  logic [2:0]  flt_q;

  x86e_pkg::srch_req_t sreq;
  x86e_pkg::srch_rsp_t srsp;
  x86e_pkg::slot_wr_t  swr;

  x86e_slot_tbl u_tbl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .wr_i   (swr),
    .rsp_o  (srsp)
  );

  // ---------------- buffer assembly
  logic [7:0]  bb [x86e_pkg::BufLen];
  logic [BIB-1:0] bn;
  logic        b_alloc;
  logic        b_ufault;
  logic        b_sfault;
  logic [SIB-1:0] b_aslot, b_dslot;
  logic [16:0] b_end;

  function automatic logic [3:0] tr(input logic [15:0] i);
    tr = 4'd8 + i[3:0];
  endfunction

  always_comb begin
    logic [3:0] r;
    logic [SIB-1:0] ds;
    logic [SIB-1:0] as;
    logic [31:0] dp;
    for (int k = 0; k < x86e_pkg::BufLen; k++) bb[k] = 8'h00;
    bn = '0;
    b_alloc = 1'b0;
    b_ufault = 1'b0;
    b_sfault = 1'b0;
    ds = dslot_q;
    as = aslot_q;
    r = 4'd0;
    dp = 32'd0;
    case (act_q)
      x86e_pkg::ActBegin: begin
        bb[0] = 8'h55; bb[1] = 8'h48; bb[2] = 8'h89; bb[3] = 8'hE5;
        bb[4] = 8'h48; bb[5] = 8'h81; bb[6] = 8'hEC;
        bn = BIB'(11);
      end
      x86e_pkg::ActEnd: begin
        if (scnt_q != '0) begin
          bb[0] = 8'h48; bb[1] = 8'h8b; bb[2] = 8'h85;
          {bb[6], bb[5], bb[4], bb[3]} = x86e_pkg::slot_disp('0);
          bn = BIB'(7);
        end
        bb[bn] = 8'h48; bb[bn+1] = 8'h81; bb[bn+2] = 8'hC4;
        bb[bn+7] = 8'h5D; bb[bn+8] = 8'hc3;
        bn = bn + BIB'(9);
      end
      x86e_pkg::ActAssign: begin
        if (dk_q == x86e_pkg::KindVar && !dfound_q) b_alloc = 1'b1;
        if (ak_q == x86e_pkg::KindVar && !afound_q) begin
          if (b_alloc && ai_q == di_q) as = scnt_q[SIB-1:0];
          else b_ufault = 1'b1;
        end
        if (b_alloc) begin
          if (scnt_q >= SCB'(x86e_pkg::SlotCount) ||
              ({1'b0, frame_q} + 13'd8) > 13'(x86e_pkg::FrameMax))
            b_sfault = 1'b1;
          ds = scnt_q[SIB-1:0];
        end
        r = (dk_q == x86e_pkg::KindVar) ? 4'd0 : tr(di_q);
        if (dk_q == x86e_pkg::KindVar && ak_q == x86e_pkg::KindTemp) begin
          r = tr(ai_q);
        end else begin
          case (ak_q)
            x86e_pkg::KindConst: begin
              bb[0] = x86e_pkg::rexw(4'd0, r); bb[1] = 8'hb8 + {5'd0, r[2:0]};
              {bb[9], bb[8], bb[7], bb[6], bb[5], bb[4], bb[3], bb[2]} = av_q;
              bn = BIB'(10);
            end
            x86e_pkg::KindVar: begin
              bb[0] = x86e_pkg::rexw(r, 4'd5); bb[1] = 8'h8b;
              bb[2] = 8'h85 | {2'd0, r[2:0], 3'd0};
              {bb[6], bb[5], bb[4], bb[3]} = x86e_pkg::slot_disp(as);
              bn = BIB'(7);
            end
            default: begin
              bb[0] = x86e_pkg::rexw(tr(ai_q), r); bb[1] = 8'h89;
              bb[2] = 8'hC0 | {2'd0, ai_q[2:0], 3'd0} | {5'd0, r[2:0]};
              bn = BIB'(3);
            end
          endcase
          r = 4'd0;
        end
        if (dk_q == x86e_pkg::KindVar) begin
          dp = x86e_pkg::slot_disp(ds);
          bb[bn] = x86e_pkg::rexw(r, 4'd5); bb[bn+1] = 8'h89;
          bb[bn+2] = 8'h85 | {2'd0, r[2:0], 3'd0};
          {bb[bn+6], bb[bn+5], bb[bn+4], bb[bn+3]} = dp;
          bn = bn + BIB'(7);
        end
      end
      default: begin
        if ((ak_q == x86e_pkg::KindVar && !afound_q) ||
            (bk_q == x86e_pkg::KindVar && !bfound_q) ||
            (dk_q == x86e_pkg::KindVar && !dfound_q)) b_ufault = 1'b1;
        for (int s = 0; s < 2; s++) begin
          logic [1:0] kk;
          logic [15:0] ii;
          logic [63:0] vv;
          logic [SIB-1:0] ss;
          kk = s == 0 ? ak_q : bk_q;
          ii = s == 0 ? ai_q : bi_q;
          vv = s == 0 ? av_q : bv_q;
          ss = s == 0 ? aslot_q : bslot_q;
          r = s == 0 ? 4'd0 : 4'd15;
          case (kk)
            x86e_pkg::KindConst: begin
              bb[bn] = x86e_pkg::rexw(4'd0, r); bb[bn+1] = 8'hb8 + {5'd0, r[2:0]};
              {bb[bn+9], bb[bn+8], bb[bn+7], bb[bn+6],
               bb[bn+5], bb[bn+4], bb[bn+3], bb[bn+2]} = vv;
              bn = bn + BIB'(10);
            end
            x86e_pkg::KindVar: begin
              bb[bn] = x86e_pkg::rexw(r, 4'd5); bb[bn+1] = 8'h8b;
              bb[bn+2] = 8'h85 | {2'd0, r[2:0], 3'd0};
              {bb[bn+6], bb[bn+5], bb[bn+4], bb[bn+3]} = x86e_pkg::slot_disp(ss);
              bn = bn + BIB'(7);
            end
            default: begin
              bb[bn] = x86e_pkg::rexw(tr(ii), r); bb[bn+1] = 8'h89;
              bb[bn+2] = 8'hC0 | {2'd0, ii[2:0], 3'd0} | {5'd0, r[2:0]};
              bn = bn + BIB'(3);
            end
          endcase
        end
        case (op_q)
          x86e_pkg::OpAdd: begin
            bb[bn] = 8'h49; bb[bn+1] = 8'h03; bb[bn+2] = 8'hC7; bn = bn + BIB'(3);
          end
          x86e_pkg::OpSub: begin
            bb[bn] = 8'h49; bb[bn+1] = 8'h2b; bb[bn+2] = 8'hC7; bn = bn + BIB'(3);
          end
          x86e_pkg::OpMul: begin
            bb[bn] = 8'h49; bb[bn+1] = 8'h0F; bb[bn+2] = 8'haf; bb[bn+3] = 8'hC7;
            bn = bn + BIB'(4);
          end
          default: begin
            bb[bn] = 8'h48; bb[bn+1] = 8'h33; bb[bn+2] = 8'hD2;
            bb[bn+3] = 8'h49; bb[bn+4] = 8'hf7; bb[bn+5] = 8'hFF;
            bn = bn + BIB'(6);
            if (op_q == x86e_pkg::OpMod) begin
              bb[bn] = 8'h48; bb[bn+1] = 8'h89; bb[bn+2] = 8'hD0;
              bn = bn + BIB'(3);
            end
          end
        endcase
        if (dk_q == x86e_pkg::KindVar) begin
          bb[bn] = 8'h48; bb[bn+1] = 8'h89; bb[bn+2] = 8'h85;
          {bb[bn+6], bb[bn+5], bb[bn+4], bb[bn+3]} = x86e_pkg::slot_disp(dslot_q);
          bn = bn + BIB'(7);
        end else begin
          bb[bn] = x86e_pkg::rexw(4'd0, tr(di_q)); bb[bn+1] = 8'h89;
          bb[bn+2] = 8'hC0 | {5'd0, di_q[2:0]};
          bn = bn + BIB'(3);
        end
      end
    endcase
    b_aslot = as;
    b_dslot = ds;
    b_end = {1'b0, cur_q} + {{(17 - BIB){1'b0}}, bn};
  end

  // ---------------- operand check
  logic chk_bad;
  always_comb begin
    chk_bad = 1'b0;
    if (action_i > x86e_pkg::ActFinal) chk_bad = 1'b1;
    else if (action_i == x86e_pkg::ActAssign || action_i == x86e_pkg::ActBinop) begin
      if (dest_kind_i == x86e_pkg::KindConst || dest_kind_i > x86e_pkg::KindTemp)
        chk_bad = 1'b1;
      if (dest_kind_i == x86e_pkg::KindTemp && dest_ident_i >= 16'(x86e_pkg::TempRegs))
        chk_bad = 1'b1;
      if (src_a_kind_i > x86e_pkg::KindTemp ||
          (src_a_kind_i == x86e_pkg::KindTemp && src_a_ident_i >= 16'(x86e_pkg::TempRegs)))
        chk_bad = 1'b1;
      if (action_i == x86e_pkg::ActBinop &&
          (bin_op_i > x86e_pkg::OpMod || src_b_kind_i > x86e_pkg::KindTemp ||
           (src_b_kind_i == x86e_pkg::KindTemp &&
            src_b_ident_i >= 16'(x86e_pkg::TempRegs))))
        chk_bad = 1'b1;
    end
  end

  logic bad_q;
  logic srch_go;
  logic [15:0] mask_key;
  always_comb begin
    srch_go = 1'b0;
    mask_key = '0;
    case (state_q)
      SSrchD: begin srch_go = (dk_q == x86e_pkg::KindVar); mask_key = di_q; end
      SSrchA: begin srch_go = (ak_q == x86e_pkg::KindVar); mask_key = ai_q; end
      SSrchB: begin
        srch_go = (bk_q == x86e_pkg::KindVar) && (act_q == x86e_pkg::ActBinop);
        mask_key = bi_q;
      end
      default: ;
    endcase
  end

  logic sbusy_q;
  assign sreq.start = srch_go && !sbusy_q;
  assign sreq.key   = mask_key;
  assign sreq.count = scnt_q;

  assign busy_o = (state_q != SIdle);
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, cap_q} : 32'd0;

  wire cfg_we = psel && penable && pwrite && (paddr == 2'd0);
  wire do_fault = b_ufault || (b_alloc && b_sfault) || (b_end > {1'b0, cap_q});

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      act_q <= action_i; op_q <= bin_op_i;
      dk_q <= dest_kind_i; di_q <= dest_ident_i;
      ak_q <= src_a_kind_i; ai_q <= src_a_ident_i; av_q <= src_a_value_i;
      bk_q <= src_b_kind_i; bi_q <= src_b_ident_i; bv_q <= src_b_value_i;
      bad_q <= chk_bad;
    end
  end

  always_comb begin
    swr.we   = (state_q == SBuild) && !do_fault && b_alloc;
    swr.addr = b_dslot;
    swr.key  = di_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cap_q <= 16'hFFFF; scnt_q <= '0; frame_q <= 12'd8;
      cur_q <= '0; ppos_q[0] <= '0; ppos_q[1] <= '0; pval_q <= '0;
      dfound_q <= 1'b0; afound_q <= 1'b0; bfound_q <= 1'b0;
      dslot_q <= '0; aslot_q <= '0; bslot_q <= '0; sbusy_q <= 1'b0;
      bidx_q <= '0; fcnt_q <= '0;
      strobe_q <= 1'b0; last_q <= 1'b0; kind_q <= '0; byte_q <= '0;
      pos_q <= '0; pv_q <= '0; flt_q <= '0;
    end else begin
      if (cfg_we) cap_q <= pwdata[15:0];
      strobe_q <= 1'b0;
      if (sreq.start) sbusy_q <= 1'b1;
      if (srsp.done) sbusy_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (start_i) state_q <= SCheck;
        end
        SCheck: begin
          dfound_q <= 1'b0; afound_q <= 1'b0; bfound_q <= 1'b0;
          if (bad_q) begin
            strobe_q <= 1'b1; kind_q <= x86e_pkg::ItemFault; byte_q <= '0;
            pos_q <= '0; pv_q <= '0; flt_q <= x86e_pkg::FltOperand; last_q <= 1'b1;
            state_q <= SIdle;
          end else if (act_q == x86e_pkg::ActFinal) begin
            fcnt_q <= '0; state_q <= SFinal;
          end else if (act_q == x86e_pkg::ActAssign || act_q == x86e_pkg::ActBinop) begin
            state_q <= SSrchD;
          end else begin
            state_q <= SBuild;
          end
        end
        SSrchD: begin
          if (dk_q != x86e_pkg::KindVar) state_q <= SSrchA;
          else if (srsp.done && sbusy_q) begin
            dfound_q <= srsp.found; dslot_q <= srsp.idx; state_q <= SSrchA;
          end
        end
        SSrchA: begin
          if (ak_q != x86e_pkg::KindVar) state_q <= SSrchB;
          else if (srsp.done && sbusy_q) begin
            afound_q <= srsp.found; aslot_q <= srsp.idx; state_q <= SSrchB;
          end
        end
        SSrchB: begin
          if (bk_q != x86e_pkg::KindVar || act_q != x86e_pkg::ActBinop)
            state_q <= SBuild;
          else if (srsp.done && sbusy_q) begin
            bfound_q <= srsp.found; bslot_q <= srsp.idx; state_q <= SBuild;
          end
        end
        SBuild: begin
          if (do_fault) begin
            strobe_q <= 1'b1; kind_q <= x86e_pkg::ItemFault; byte_q <= '0;
            pos_q <= '0; pv_q <= '0; last_q <= 1'b1;
            flt_q <= b_ufault ? x86e_pkg::FltUnknown :
                     (b_alloc && b_sfault) ? x86e_pkg::FltSlots : x86e_pkg::FltBuffer;
            state_q <= SIdle;
          end else begin
            // freeze slot choice so the byte buffer stays stable while emitting
            dfound_q <= 1'b1; afound_q <= 1'b1;
            dslot_q <= b_dslot; aslot_q <= b_aslot;
            if (b_alloc) begin
              scnt_q <= scnt_q + 1'b1; frame_q <= frame_q + 12'd8;
            end
            if (act_q == x86e_pkg::ActBegin) begin
              ppos_q[0] <= cur_q + 16'd7; pval_q[0] <= 1'b1;
            end
            if (act_q == x86e_pkg::ActEnd) begin
              ppos_q[1] <= cur_q + ((scnt_q != '0) ? 16'd10 : 16'd3);
              pval_q[1] <= 1'b1;
            end
            bidx_q <= '0;
            state_q <= SEmit;
          end
        end
        SEmit: begin
          strobe_q <= 1'b1; kind_q <= x86e_pkg::ItemByte; byte_q <= bb[bidx_q];
          pos_q <= cur_q; pv_q <= '0; flt_q <= x86e_pkg::FltNone;
          last_q <= (bidx_q == bn - 1'b1);
          cur_q <= cur_q + 16'd1;
          bidx_q <= bidx_q + 1'b1;
          if (bidx_q == bn - 1'b1) state_q <= SIdle;
        end
        SFinal: begin
          fcnt_q <= fcnt_q + 1'b1;
          byte_q <= '0; flt_q <= x86e_pkg::FltNone;
          if (fcnt_q == 2'd2) begin
            strobe_q <= 1'b1; kind_q <= x86e_pkg::ItemSize; pos_q <= cur_q;
            pv_q <= '0; last_q <= 1'b1; state_q <= SIdle;
          end else if (pval_q[fcnt_q[0]]) begin
            strobe_q <= 1'b1; kind_q <= x86e_pkg::ItemPatch;
            pos_q <= ppos_q[fcnt_q[0]]; pv_q <= frame_q; last_q <= 1'b0;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign strobe_o = strobe_q;
  assign item_kind_o = kind_q;
  assign code_byte_o = byte_q;
  assign position_o = pos_q;
  assign patch_value_o = pv_q;
  assign fault_o = flt_q;
  assign last_o = last_q;

  // slot count and frame size move together
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $changed(scnt_q) |-> $changed(frame_q))
    else $error("frame size out of step with slot count");

  a_busy_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && last_q) |-> (state_q == SIdle))
    else $error("last result while still busy");

  a_no_alloc_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && kind_q == x86e_pkg::ItemFault) |-> $stable(scnt_q))
    else $error("fault changed slot count");

endmodule

// ===== dv/tb_x86_64_three_address_code_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x86_64_three_address_code_emitter
// self-checking bench: IR requests are sent with random gaps, every result is
// predicted from an in-bench encoder model and compared field by field
// ----------------------------------------------------------------------------
module tb_x86_64_three_address_code_emitter;
  import x86e_pkg::*;

  localparam int unsigned StallLimit = 20000;

  typedef struct {
    logic [2:0]  action;
    logic [2:0]  op;
    logic [1:0]  dk;
    logic [15:0] di;
    logic [1:0]  ak;
    logic [15:0] ai;
    logic [63:0] av;
    logic [1:0]  bk;
    logic [15:0] bi;
    logic [63:0] bv;
  } ir_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [15:0] pos;
    logic [11:0] pv;
    logic [2:0]  flt;
    logic        last;
  } emit_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  action_i = '0;
  logic [2:0]  bin_op_i = '0;
  logic [1:0]  dest_kind_i = '0;
  logic [15:0] dest_ident_i = '0;
  logic [1:0]  src_a_kind_i = '0;
  logic [15:0] src_a_ident_i = '0;
  logic signed [63:0] src_a_value_i = '0;
  logic [1:0]  src_b_kind_i = '0;
  logic [15:0] src_b_ident_i = '0;
  logic signed [63:0] src_b_value_i = '0;
  logic        strobe_o;
  logic [1:0]  item_kind_o;
  logic [7:0]  code_byte_o;
  logic [15:0] position_o;
  logic [11:0] patch_value_o;
  logic [2:0]  fault_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  x86_64_three_address_code_emitter dut (.*);

  always #6 clk_i = ~clk_i;

  // encoder model state
  logic [15:0] slot_keys [SlotCount];
  int unsigned slot_count = 0;
  int unsigned frame_size = 8;
  int unsigned code_cursor = 0;
  int unsigned patch_pos [2] = '{0, 0};
  bit          patch_valid [2] = '{0, 0};
  int unsigned code_capacity = 65535;

  logic [7:0]  enc_bytes [$];
  emit_res_t   expected_q [$];
  int          errors = 0;
  bit          no_idle = 0;
  int unsigned stall_cycles = 0;
  logic [15:0] key_pool [12];

  function automatic logic [7:0] rex_w(input logic [3:0] r, input logic [3:0] rm);
    return 8'h48 | {5'd0, r[3], 2'd0} | {7'd0, rm[3]};
  endfunction

  function automatic void put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) enc_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void mov_reg(input logic [3:0] rm, input logic [3:0] r);
    enc_bytes.push_back(rex_w(r, rm));
    enc_bytes.push_back(8'h89);
    enc_bytes.push_back(8'hC0 | {2'd0, r[2:0], rm[2:0]});
  endfunction

  function automatic void slot_access(input logic [7:0] opc, input logic [3:0] r,
                                      input int unsigned slot);
    logic [31:0] disp;
    disp = 32'd0 - (32'd16 + 32'(8 * slot));
    enc_bytes.push_back(rex_w(r, 4'd5));
    enc_bytes.push_back(opc);
    enc_bytes.push_back(8'h80 | {2'd0, r[2:0], 3'd5});
    put32(disp);
  endfunction

  function automatic void load_operand(input logic [3:0] r, input logic [1:0] kind,
                                       input logic [15:0] ident, input logic [63:0] val,
                                       input int unsigned slot);
    if (kind == KindConst) begin
      enc_bytes.push_back(rex_w(4'd0, r));
      enc_bytes.push_back(8'hb8 + {5'd0, r[2:0]});
      for (int i = 0; i < 8; i++) enc_bytes.push_back(val[8*i +: 8]);
    end else if (kind == KindVar) begin
      slot_access(8'h8b, r, slot);
    end else begin
      mov_reg(r, 4'd8 + ident[3:0]);
    end
  endfunction

  function automatic bit find_slot(input logic [15:0] key, output int unsigned idx);
    idx = 0;
    for (int unsigned i = 0; i < slot_count; i++)
      if (slot_keys[i] == key) begin
        idx = i;
        return 1;
      end
    return 0;
  endfunction

  function automatic bit operand_ok(input logic [1:0] kind, input logic [15:0] ident);
    if (kind > KindTemp) return 0;
    if (kind == KindTemp && ident >= TempRegs) return 0;
    return 1;
  endfunction

  // fills enc_bytes and returns the fault code of the request
  function automatic logic [2:0] encode_ir(input ir_req_t r, output int patch_sel,
                                           output bit alloc, output int unsigned d_slot);
    int unsigned a_slot, b_slot, lim;
    enc_bytes.delete();
    patch_sel = -1;
    alloc = 0;
    d_slot = 0;
    a_slot = 0;
    b_slot = 0;
    if (r.action > ActFinal) return FltOperand;
    if (r.action == ActAssign || r.action == ActBinop) begin
      if (r.dk == KindConst || r.dk > KindTemp) return FltOperand;
      if (r.dk == KindTemp && r.di >= TempRegs) return FltOperand;
      if (!operand_ok(r.ak, r.ai)) return FltOperand;
      if (r.action == ActBinop && (r.op > OpMod || !operand_ok(r.bk, r.bi)))
        return FltOperand;
    end
    case (r.action)
      ActBegin: begin
        enc_bytes.push_back(8'h55);
        mov_reg(4'd5, 4'd4);
        enc_bytes.push_back(8'h48);
        enc_bytes.push_back(8'h81);
        enc_bytes.push_back(8'hEC);
        put32(32'd0);
        patch_sel = 0;
      end
      ActEnd: begin
        if (slot_count > 0) slot_access(8'h8b, 4'd0, 0);
        enc_bytes.push_back(8'h48);
        enc_bytes.push_back(8'h81);
        enc_bytes.push_back(8'hC4);
        put32(32'd0);
        enc_bytes.push_back(8'h5D);
        enc_bytes.push_back(8'hc3);
        patch_sel = 1;
      end
      ActAssign: begin
        if (r.dk == KindVar && !find_slot(r.di, d_slot)) alloc = 1;
        if (r.ak == KindVar && !find_slot(r.ai, a_slot)) begin
          if (alloc && r.ai == r.di) a_slot = slot_count;
          else return FltUnknown;
        end
        if (alloc) begin
          if (slot_count >= SlotCount || frame_size + 8 > FrameMax) return FltSlots;
          d_slot = slot_count;
        end
        if (r.dk == KindVar) begin
          if (r.ak == KindTemp) slot_access(8'h89, 4'd8 + r.ai[3:0], d_slot);
          else begin
            load_operand(4'd0, r.ak, r.ai, r.av, a_slot);
            slot_access(8'h89, 4'd0, d_slot);
          end
        end else begin
          load_operand(4'd8 + r.di[3:0], r.ak, r.ai, r.av, a_slot);
        end
      end
      default: begin
        if (r.ak == KindVar && !find_slot(r.ai, a_slot)) return FltUnknown;
        if (r.bk == KindVar && !find_slot(r.bi, b_slot)) return FltUnknown;
        if (r.dk == KindVar && !find_slot(r.di, d_slot)) return FltUnknown;
        load_operand(4'd0, r.ak, r.ai, r.av, a_slot);
        load_operand(4'd15, r.bk, r.bi, r.bv, b_slot);
        case (r.op)
          OpAdd: enc_bytes = {enc_bytes, 8'h49, 8'h03, 8'hC7};
          OpSub: enc_bytes = {enc_bytes, 8'h49, 8'h2b, 8'hC7};
          OpMul: enc_bytes = {enc_bytes, 8'h49, 8'h0F, 8'haf, 8'hC7};
          default: begin
            enc_bytes = {enc_bytes, 8'h48, 8'h33, 8'hD2, 8'h49, 8'hf7, 8'hFF};
            if (r.op == OpMod) mov_reg(4'd0, 4'd2);
          end
        endcase
        if (r.dk == KindVar) slot_access(8'h89, 4'd0, d_slot);
        else mov_reg(4'd8 + r.di[3:0], 4'd0);
      end
    endcase
    lim = code_capacity < 65535 ? code_capacity : 65535;
    if (code_cursor + enc_bytes.size() > lim) return FltBuffer;
    return FltNone;
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] code,
                                      input int unsigned pos, input int unsigned pv,
                                      input logic [2:0] flt, input bit last);
    emit_res_t e;
    e.kind = kind;
    e.code = code;
    e.pos = 16'(pos);
    e.pv = 12'(pv);
    e.flt = flt;
    e.last = last;
    expected_q.push_back(e);
  endfunction

  function automatic void predict_results(input ir_req_t r);
    int patch_sel;
    bit alloc;
    int unsigned d_slot, n;
    logic [2:0] flt;
    if (r.action == ActFinal) begin
      for (int i = 0; i < 2; i++)
        if (patch_valid[i]) push_result(ItemPatch, 0, patch_pos[i], frame_size, FltNone, 0);
      push_result(ItemSize, 0, code_cursor, 0, FltNone, 1);
      return;
    end
    flt = encode_ir(r, patch_sel, alloc, d_slot);
    if (flt != FltNone) begin
      push_result(ItemFault, 0, 0, 0, flt, 1);
      return;
    end
    if (alloc) begin
      slot_keys[d_slot] = r.di;
      slot_count++;
      frame_size += 8;
    end
    n = enc_bytes.size();
    for (int unsigned i = 0; i < n; i++)
      push_result(ItemByte, enc_bytes[i], code_cursor + i, 0, FltNone, i == n - 1);
    if (patch_sel == 0) begin
      patch_pos[0] = code_cursor + 7;
      patch_valid[0] = 1;
    end else if (patch_sel == 1) begin
      patch_pos[1] = code_cursor + (slot_count > 0 ? 10 : 3);
      patch_valid[1] = 1;
    end
    code_cursor += n;
  endfunction

  function automatic ir_req_t mk(input logic [2:0] action, input logic [2:0] op,
                                 input logic [1:0] dk, input logic [15:0] di,
                                 input logic [1:0] ak, input logic [15:0] ai,
                                 input logic [63:0] av, input logic [1:0] bk,
                                 input logic [15:0] bi, input logic [63:0] bv);
    ir_req_t r;
    r.action = action;
    r.op = op;
    r.dk = dk;
    r.di = di;
    r.ak = ak;
    r.ai = ai;
    r.av = av;
    r.bk = bk;
    r.bi = bi;
    r.bv = bv;
    return r;
  endfunction

  task automatic send_request(input ir_req_t r);
    if (!no_idle && $urandom_range(0, 99) < 26) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    @(negedge clk_i);
    action_i <= r.action;
    bin_op_i <= r.op;
    dest_kind_i <= r.dk;
    dest_ident_i <= r.di;
    src_a_kind_i <= r.ak;
    src_a_ident_i <= r.ai;
    src_a_value_i <= r.av;
    src_b_kind_i <= r.bk;
    src_b_ident_i <= r.bi;
    src_b_value_i <= r.bv;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    predict_results(r);
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic write_capacity(input int unsigned value);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    code_capacity = value & 16'hFFFF;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ir_req_t random_request();
    ir_req_t r;
    int w;
    if ($urandom_range(0, 99) < 15) begin
      r = mk($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 3), $urandom,
             $urandom_range(0, 3), $urandom, rand64(), $urandom_range(0, 3), $urandom,
             rand64());
      return r;
    end
    w = $urandom_range(0, 99);
    r.action = w < 40 ? ActAssign : w < 82 ? ActBinop : w < 87 ? ActBegin :
               w < 93 ? ActEnd : ActFinal;
    r.op = $urandom_range(OpAdd, OpMod);
    r.dk = $urandom_range(KindVar, KindTemp);
    r.ak = $urandom_range(KindConst, KindTemp);
    r.bk = $urandom_range(KindConst, KindTemp);
    r.di = r.dk == KindVar ? key_pool[$urandom_range(0, 11)] : $urandom_range(0, 6);
    r.ai = r.ak == KindTemp ? $urandom_range(0, 6) : key_pool[$urandom_range(0, 11)];
    r.bi = r.bk == KindTemp ? $urandom_range(0, 6) : key_pool[$urandom_range(0, 11)];
    r.av = rand64();
    r.bv = $urandom_range(0, 3) == 0 ? 64'(signed'($urandom_range(0, 20)) - 10) : rand64();
    return r;
  endfunction

  task automatic test_directed();
    logic [63:0] mx, mn;
    mx = 64'h7FFF_FFFF_FFFF_FFFF;
    mn = 64'h8000_0000_0000_0000;
    send_request(mk(ActEnd, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(ActBegin, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindVar, 16'hFFFF, KindConst, 0, mx, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindVar, 16'h0000, KindConst, 16'hFFFF, mn, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindTemp, 0, KindVar, 16'hFFFF, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindTemp, 6, KindTemp, 0, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindVar, 16'h5A5A, KindVar, 16'h5A5A, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindVar, 16'hFFFF, KindTemp, 6, 0, 0, 0, 0));
    send_request(mk(ActBinop, OpAdd, KindVar, 16'hFFFF, KindVar, 16'hFFFF, 0,
                    KindConst, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(mk(ActBinop, OpSub, KindTemp, 1, KindVar, 16'h0000, 0, KindTemp, 0, 0));
    send_request(mk(ActBinop, OpMul, KindVar, 16'h0000, KindTemp, 6, 0, KindConst, 0, mx));
    send_request(mk(ActBinop, OpDiv, KindTemp, 0, KindVar, 16'hFFFF, 0, KindVar, 16'h5A5A, 0));
    send_request(mk(ActBinop, OpMod, KindVar, 16'h5A5A, KindConst, 0, mn, KindVar, 0, 0));
    send_request(mk(ActAssign, 0, KindTemp, 2, KindVar, 16'h1234, 0, 0, 0, 0));
    send_request(mk(ActBinop, OpAdd, KindVar, 16'h1234, KindTemp, 0, 0, KindTemp, 1, 0));
    send_request(mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(3'd7, 3'd7, 2'd3, 16'hFFFF, 2'd3, 16'hFFFF, mx, 2'd3, 16'hFFFF, mx));
    send_request(mk(ActBinop, 3'd7, KindTemp, 0, KindTemp, 0, 0, KindTemp, 0, 0));
    send_request(mk(ActAssign, 0, KindConst, 0, KindConst, 0, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, 2'd3, 0, KindConst, 0, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindTemp, 0, 2'd3, 0, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindTemp, 7, KindConst, 0, 0, 0, 0, 0));
    send_request(mk(ActBinop, OpAdd, KindTemp, 0, KindTemp, 0, 0, 2'd3, 0, 0));
    send_request(mk(ActEnd, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(ActFinal, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(ActBegin, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_capacity();
    write_capacity(0);
    send_request(mk(ActAssign, 0, KindTemp, 3, KindConst, 0, 64'h1, 0, 0, 0));
    send_request(mk(ActFinal, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    write_capacity(code_cursor + 13);
    send_request(mk(ActAssign, 0, KindTemp, 3, KindConst, 0, 64'h2, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindTemp, 4, KindTemp, 3, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindTemp, 5, KindTemp, 3, 0, 0, 0, 0));
    write_capacity(32'hFFFF_FFFF);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 2 && i < count / 2 + 60);
      if (i == count / 4) write_capacity(code_cursor + $urandom_range(60, 300));
      if (i == count / 4 + 60) write_capacity(16'hFFFF);
      send_request(random_request());
    end
    no_idle = 0;
  endtask

  task automatic test_slot_table_full();
    int unsigned idx;
    logic [15:0] key;
    no_idle = 1;
    key = 16'h0001;
    while (slot_count < SlotCount) begin
      if (!find_slot(key, idx))
        send_request(mk(ActAssign, 0, KindVar, key, KindConst, 0, rand64(), 0, 0, 0));
      key = key + 16'd7;
    end
    no_idle = 0;
    while (find_slot(key, idx)) key = key + 16'd7;
    send_request(mk(ActAssign, 0, KindVar, key, KindConst, 0, 0, 0, 0, 0));
    send_request(mk(ActAssign, 0, KindVar, key, KindVar, key, 0, 0, 0, 0));
    send_request(mk(ActBinop, OpAdd, KindVar, slot_keys[SlotCount-1], KindVar,
                    slot_keys[SlotCount-1], 0, KindVar, slot_keys[0], 0));
    send_request(mk(ActEnd, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(ActFinal, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d byte %h pos %0d", $time, item_kind_o,
                 code_byte_o, position_o);
        errors++;
      end else begin
        emit_res_t e;
        e = expected_q.pop_front();
        if (item_kind_o !== e.kind || code_byte_o !== e.code || position_o !== e.pos ||
            patch_value_o !== e.pv || fault_o !== e.flt || last_o !== e.last) begin
          $display("%0t: mismatch expected kind %0d byte %h pos %0d pv %0d flt %0d last %0b",
                   $time, e.kind, e.code, e.pos, e.pv, e.flt, e.last);
          $display("%0t:          actual   kind %0d byte %h pos %0d pv %0d flt %0d last %0b",
                   $time, item_kind_o, code_byte_o, position_o, patch_value_o, fault_o, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (strobe_o || (start_i && !busy_o) || psel) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("tb_x86_64_three_address_code_emitter NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 12; i++) key_pool[i] = $urandom;
    key_pool[0] = 16'hFFFF;
    key_pool[1] = 16'h0000;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_capacity();
    test_random(110);
    test_slot_table_full();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("tb_x86_64_three_address_code_emitter OK");
    else $display("tb_x86_64_three_address_code_emitter NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
design/x86e_pkg.sv
design/x86e_slot_tbl.sv
design/x86_64_three_address_code_emitter.sv
dv/tb_x86_64_three_address_code_emitter.sv
